### src/kdpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_pkg - shared types and constants for the key debounce classifier
// Event codes, register indexes, configuration and result beat types.
// ----------------------------------------------------------------------------
package kdpc_pkg;

    localparam int MAX_KEYS       = 6;
    localparam int DEF_NUM_KEYS   = 6;
    localparam int DEF_TIMER_BITS = 16;

    localparam int TIME_W    = 16;
    localparam int STEP_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK   = 2'd3;

    localparam logic [TIME_W-1:0]   RST_DEBOUNCE_TIME = 16'd20;
    localparam logic [TIME_W-1:0]   RST_LONG_TIME     = 16'd1000;
    localparam logic [STEP_W-1:0]   RST_TICK_STEP     = 8'd10;
    localparam logic [MAX_KEYS-1:0] RST_ACTIVE_MASK   = 6'd0;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_UP    = 3'd2,
        EV_SHORT = 3'd3,
        EV_LONG  = 3'd4
    } t_event;

    // timing settings seen by every lane
    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] long_press_time;
        logic [STEP_W-1:0] tick_step;
    } t_timing;

    // one result beat
    typedef struct packed {
        logic [MAX_KEYS-1:0][2:0] events;
        logic [MAX_KEYS-1:0]      pressed;
    } t_result;

endpackage
`default_nettype wire

### src/kdpc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_lane - debounce and press classification for one key
// Holds the key's raw level, stable level and both timers; updates on a tick.
// ----------------------------------------------------------------------------
module kdpc_lane #(
    parameter int TIMER_BITS = kdpc_pkg::DEF_TIMER_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick,
    input  wire logic              i_pin,
    input  wire logic              i_active,
    input  wire kdpc_pkg::t_timing i_timing,
    output kdpc_pkg::t_event       o_event,
    output logic                   o_stable
);
    import kdpc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;

    logic                  r_raw;
    logic                  r_stable;      // also the level before this tick
    logic [TIMER_BITS-1:0] r_deb_timer;
    logic [TIMER_BITS-1:0] r_press_timer;

    logic                  n_raw;
    logic                  n_stable;
    logic [TIMER_BITS-1:0] n_deb_timer;
    logic [TIMER_BITS-1:0] n_press_timer;

    logic                  now_pressed;
    logic [TIMER_BITS:0]   deb_sum;
    logic [TIMER_BITS-1:0] deb_sat;
    logic [TIMER_BITS:0]   press_sum;
    logic [TIMER_BITS-1:0] press_sat;
    logic [CMP_W-1:0]      deb_time_w;
    logic [CMP_W-1:0]      long_time_w;
    logic [CMP_W-1:0]      press_old_w;

    assign now_pressed = ~(i_pin ^ i_active);
    assign deb_time_w  = CMP_W'(i_timing.debounce_time);
    assign long_time_w = CMP_W'(i_timing.long_press_time);
    assign press_old_w = CMP_W'(r_press_timer);

    assign deb_sum   = {1'b0, r_deb_timer} + (TIMER_BITS+1)'(i_timing.tick_step);
    assign deb_sat   = deb_sum[TIMER_BITS] ? '1 : deb_sum[TIMER_BITS-1:0];
    assign press_sum = {1'b0, r_press_timer} + (TIMER_BITS+1)'(i_timing.tick_step);
    assign press_sat = press_sum[TIMER_BITS] ? '1 : press_sum[TIMER_BITS-1:0];

    always_comb begin
        n_raw         = r_raw;
        n_stable      = r_stable;
        n_deb_timer   = r_deb_timer;
        n_press_timer = r_press_timer;
        o_event       = EV_NONE;

        if (now_pressed != r_raw) begin
            n_raw       = now_pressed;
            n_deb_timer = '0;
        end else if (CMP_W'(deb_sat) >= deb_time_w) begin
            n_stable    = r_raw;
            n_deb_timer = TIMER_BITS'(i_timing.debounce_time);
        end else begin
            n_deb_timer = deb_sat;
        end

        if (n_stable && !r_stable) begin
            o_event       = EV_DOWN;
            n_press_timer = '0;
        end else if (!n_stable && r_stable) begin
            if (press_old_w >= deb_time_w && press_old_w < long_time_w) begin
                o_event = EV_SHORT;
            end else begin
                o_event = EV_UP;
            end
        end else if (n_stable) begin
            n_press_timer = press_sat;
            if (CMP_W'(press_sat) == long_time_w) begin
                o_event = EV_LONG;
            end
        end
    end

    assign o_stable = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b0;
            r_stable      <= 1'b0;
            r_deb_timer   <= '0;
            r_press_timer <= '0;
        end else if (i_tick) begin
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_deb_timer   <= n_deb_timer;
            r_press_timer <= n_press_timer;
        end
    end

endmodule
`default_nettype wire

### src/kdpc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_merge - queues each lane result beat behind a two-entry skid
// Output register plus skid register; ready only drops when both are full.
// ----------------------------------------------------------------------------
module kdpc_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire kdpc_pkg::t_result i_result,
    output logic                   o_in_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output kdpc_pkg::t_result      o_result
);
    import kdpc_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop        = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule
`default_nettype wire

### src/key_debounce_press_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_press_classifier - debounce and short/long press events
// Up to six keys scanned in parallel, one result beat per scan tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one beat is one scan tick carrying the
//   raw level of every key pin. Output channel (o_valid / i_ready): one beat
//   per tick with a 3-bit event per key (none, down, up, short, long) and the
//   debounced pressed mask. Keys at or above NUM_KEYS always report none / 0.
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
//   (0 debounce time, 1 long press time, 2 tick step, 3 active level mask).
//   Write only while the block is idle.
// Registering and throughput:
//   Each key has its own lane; a tick is classified in the accept cycle and
//   the beat is registered in the output register, or the skid when stalled.
//   One tick per cycle while o_ready is high; the lane chain sets the pace.
// Reset (i_rst_n low, synchronous): all key state and timers clear,
//   registers return to 20 / 1000 / 10 / 0, output queue empties.
// Stall: a two-entry output queue (register plus skid) keeps o_ready high
//   while one result waits; o_ready falls only with two beats unread.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier #(
    parameter int NUM_KEYS   = kdpc_pkg::DEF_NUM_KEYS,
    parameter int TIMER_BITS = kdpc_pkg::DEF_TIMER_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [kdpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [kdpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [kdpc_pkg::MAX_KEYS-1:0]      i_pin_levels,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [2:0]                              o_event_key0,
    output logic [2:0]                              o_event_key1,
    output logic [2:0]                              o_event_key2,
    output logic [2:0]                              o_event_key3,
    output logic [2:0]                              o_event_key4,
    output logic [2:0]                              o_event_key5,
    output logic [kdpc_pkg::MAX_KEYS-1:0]           o_pressed_mask
);
    import kdpc_pkg::*;

    // configuration registers
    t_timing               r_timing;
    logic [MAX_KEYS-1:0]   r_active_mask;

    logic    tick;
    t_result lane_result;
    t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.debounce_time   <= RST_DEBOUNCE_TIME;
            r_timing.long_press_time <= RST_LONG_TIME;
            r_timing.tick_step       <= RST_TICK_STEP;
            r_active_mask            <= RST_ACTIVE_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE_TIME: r_timing.debounce_time   <= i_cfg_wdata;
                REG_LONG_TIME:     r_timing.long_press_time <= i_cfg_wdata;
                REG_TICK_STEP:     r_timing.tick_step       <= i_cfg_wdata[STEP_W-1:0];
                REG_ACTIVE_MASK:   r_active_mask            <= i_cfg_wdata[MAX_KEYS-1:0];
                default: ;
            endcase
        end
    end

    assign tick = i_valid && o_ready;

    // one lane per scanned key; unscanned keys report none and not pressed
    for (genvar k = 0; k < MAX_KEYS; k++) begin : g_lane
        if (k < NUM_KEYS) begin : g_on
            t_event lane_ev;
            kdpc_lane #(
                .TIMER_BITS (TIMER_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tick   (tick),
                .i_pin    (i_pin_levels[k]),
                .i_active (r_active_mask[k]),
                .i_timing (r_timing),
                .o_event  (lane_ev),
                .o_stable (lane_result.pressed[k])
            );
            assign lane_result.events[k] = lane_ev;
        end else begin : g_off
            assign lane_result.events[k]  = EV_NONE;
            assign lane_result.pressed[k] = 1'b0;
        end
    end

    kdpc_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (tick),
        .i_result   (lane_result),
        .o_in_ready (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_event_key0   = out_result.events[0];
    assign o_event_key1   = out_result.events[1];
    assign o_event_key2   = out_result.events[2];
    assign o_event_key3   = out_result.events[3];
    assign o_event_key4   = out_result.events[4];
    assign o_event_key5   = out_result.events[5];
    assign o_pressed_mask = out_result.pressed;

endmodule
`default_nettype wire

### tb/kdpc_press_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc_press_checker - result checker for the key debounce classifier
// Snoops register writes and scan ticks, predicts each result beat and
// compares it field by field with the beat that leaves the block.
// ----------------------------------------------------------------------------
module kdpc_press_checker
    import kdpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [MAX_KEYS-1:0]   i_pin_levels,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [2:0]            i_event_key0,
    input  logic [2:0]            i_event_key1,
    input  logic [2:0]            i_event_key2,
    input  logic [2:0]            i_event_key3,
    input  logic [2:0]            i_event_key4,
    input  logic [2:0]            i_event_key5,
    input  logic [MAX_KEYS-1:0]   i_pressed_mask,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    localparam int TMR_W = DEF_TIMER_BITS;

    // shadow of the register file
    logic [TIME_W-1:0]   settle_limit;
    logic [TIME_W-1:0]   long_limit;
    logic [STEP_W-1:0]   step_ms;
    logic [MAX_KEYS-1:0] press_polarity;

    // per key debounce and press state
    logic [MAX_KEYS-1:0] seen_lvl;
    logic [MAX_KEYS-1:0] stable_lvl;
    logic [MAX_KEYS-1:0] prev_lvl;
    logic [TMR_W-1:0]    settle_t [MAX_KEYS];
    logic [TMR_W-1:0]    hold_t   [MAX_KEYS];

    t_result predicted_reports [$];
    t_result want_r;
    t_result got_r;

    function automatic logic [TMR_W-1:0] sat_add(input logic [TMR_W-1:0] a,
                                                 input logic [STEP_W-1:0] b);
        logic [TMR_W:0] sum;
        sum = {1'b0, a} + b;
        return sum[TMR_W] ? {TMR_W{1'b1}} : sum[TMR_W-1:0];
    endfunction

    // one scan tick through every key lane
    function automatic t_result classify_scan(input logic [MAX_KEYS-1:0] pins);
        t_result r;
        t_event  ev;
        logic    now;
        r = '0;
        for (int k = 0; k < DEF_NUM_KEYS; k++) begin
            ev  = EV_NONE;
            now = (pins[k] == press_polarity[k]);
            if (now != seen_lvl[k]) begin
                seen_lvl[k] = now;
                settle_t[k] = '0;
            end else begin
                settle_t[k] = sat_add(settle_t[k], step_ms);
                if (settle_t[k] >= settle_limit) begin
                    stable_lvl[k] = seen_lvl[k];
                    settle_t[k]   = settle_limit;
                end
            end
            if (stable_lvl[k] && !prev_lvl[k]) begin
                ev        = EV_DOWN;
                hold_t[k] = '0;
            end else if (!stable_lvl[k] && prev_lvl[k]) begin
                ev = (hold_t[k] >= settle_limit && hold_t[k] < long_limit) ? EV_SHORT : EV_UP;
            end else if (stable_lvl[k]) begin
                hold_t[k] = sat_add(hold_t[k], step_ms);
                if (hold_t[k] == long_limit)
                    ev = EV_LONG;
            end
            prev_lvl[k]  = stable_lvl[k];
            r.events[k]  = ev;
            r.pressed[k] = stable_lvl[k];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settle_limit   = RST_DEBOUNCE_TIME;
            long_limit     = RST_LONG_TIME;
            step_ms        = RST_TICK_STEP;
            press_polarity = RST_ACTIVE_MASK;
            seen_lvl       = '0;
            stable_lvl     = '0;
            prev_lvl       = '0;
            for (int k = 0; k < MAX_KEYS; k++) begin
                settle_t[k] = '0;
                hold_t[k]   = '0;
            end
            predicted_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE_TIME: settle_limit   = i_cfg_wdata[TIME_W-1:0];
                    REG_LONG_TIME:     long_limit     = i_cfg_wdata[TIME_W-1:0];
                    REG_TICK_STEP:     step_ms        = i_cfg_wdata[STEP_W-1:0];
                    REG_ACTIVE_MASK:   press_polarity = i_cfg_wdata[MAX_KEYS-1:0];
                    default: ;
                endcase
            end
            // output first: a beat leaving now belongs to an older tick
            if (i_out_valid && i_out_ready) begin
                got_r.events  = {i_event_key5, i_event_key4, i_event_key3,
                                 i_event_key2, i_event_key1, i_event_key0};
                got_r.pressed = i_pressed_mask;
                if (predicted_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, events %h pressed %h",
                             $time, got_r.events, got_r.pressed);
                    o_fail_count++;
                end else begin
                    want_r = predicted_reports.pop_front();
                    for (int k = 0; k < MAX_KEYS; k++) begin
                        if (got_r.events[k] !== want_r.events[k]) begin
                            $display("%0t: key %0d event expected %0d, actual %0d",
                                     $time, k, want_r.events[k], got_r.events[k]);
                            o_fail_count++;
                        end
                    end
                    if (got_r.pressed !== want_r.pressed) begin
                        $display("%0t: pressed mask expected %b, actual %b",
                                 $time, want_r.pressed, got_r.pressed);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predicted_reports.push_back(classify_scan(i_pin_levels));
        end
        o_outstanding = predicted_reports.size();
    end

endmodule

### tb/tb_key_debounce_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_press_classifier - stimulus and verdict for the classifier
// Drives scan ticks built from per-key level holds (bounces, short and long
// presses) under several register settings, with random gaps on both
// channels. Checking is done by kdpc_press_checker beside the block.
// ----------------------------------------------------------------------------
module tb_key_debounce_press_classifier;
    import kdpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no beat on either side
    localparam int N_DIRECTED     = 26;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [MAX_KEYS-1:0]   i_pin_levels;
    logic                  o_valid;
    logic                  i_ready;
    logic [2:0]            o_event_key0;
    logic [2:0]            o_event_key1;
    logic [2:0]            o_event_key2;
    logic [2:0]            o_event_key3;
    logic [2:0]            o_event_key4;
    logic [2:0]            o_event_key5;
    logic [MAX_KEYS-1:0]   o_pressed_mask;

    int fail_count;
    int reports_open;

    // current register values, used only to size the level holds
    logic [TIME_W-1:0]   cur_settle;
    logic [TIME_W-1:0]   cur_long;
    logic [STEP_W-1:0]   cur_step;

    // per key pin level generator
    logic [MAX_KEYS-1:0] key_level;
    int                  hold_left [MAX_KEYS];

    logic tx_burst;
    logic rx_burst;

    logic [MAX_KEYS-1:0] directed_pins [N_DIRECTED];

    key_debounce_press_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pin_levels   (i_pin_levels),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_key0   (o_event_key0),
        .o_event_key1   (o_event_key1),
        .o_event_key2   (o_event_key2),
        .o_event_key3   (o_event_key3),
        .o_event_key4   (o_event_key4),
        .o_event_key5   (o_event_key5),
        .o_pressed_mask (o_pressed_mask)
    );

    kdpc_press_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_pin_levels   (i_pin_levels),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_event_key0   (o_event_key0),
        .i_event_key1   (o_event_key1),
        .i_event_key2   (o_event_key2),
        .i_event_key3   (o_event_key3),
        .i_event_key4   (o_event_key4),
        .i_event_key5   (o_event_key5),
        .i_pressed_mask (o_pressed_mask),
        .o_fail_count   (fail_count),
        .o_outstanding  (reports_open)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends on a falling edge, so all
    // inputs move clear of the rising edge the block samples on.
    // ------------------------------------------------------------------------

    // One scan tick beat. Valid stays up across back-to-back beats and is only
    // dropped for a drawn gap; the pin payload holds until the beat is taken.
    task automatic send_scan(input logic [MAX_KEYS-1:0] pins);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_pin_levels = pins;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // hold off the sender until every predicted beat has come back
    task automatic drain_reports();
        i_valid = 1'b0;
        while (reports_open != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Registers change only with the block idle. The step and mask words may carry
    // upper bits that the block has to drop.
    task automatic configure(input logic [15:0] settle, input logic [15:0] long_t,
                             input logic [15:0] step_word, input logic [15:0] mask_word);
        drain_reports();
        write_reg(REG_DEBOUNCE_TIME, settle);
        write_reg(REG_LONG_TIME, long_t);
        write_reg(REG_TICK_STEP, step_word);
        write_reg(REG_ACTIVE_MASK, mask_word);
        cur_settle = settle;
        cur_long   = long_t;
        cur_step   = step_word[STEP_W-1:0];
    endtask

    // Random ticks. Each key holds its pin level for a drawn number of ticks:
    // about a third are 1-2 tick bounces that must be filtered out, the rest
    // run long enough to debounce, give a short press or reach the long press.
    // A few ticks are pure noise on all pins.
    task automatic run_random(input int n_items);
        int settle_ticks;
        int long_ticks;
        int span;
        logic [MAX_KEYS-1:0] pins;
        if (cur_step == 0) begin
            settle_ticks = 2;
            long_ticks   = 4;
        end else begin
            settle_ticks = cur_settle / cur_step + 2;
            long_ticks   = cur_long / cur_step + 2;
        end
        span = settle_ticks + long_ticks + 2;
        if (span > 300)
            span = 300;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            // now and then let the pipe run dry mid phase
            if ($urandom_range(0, 79) == 0)
                drain_reports();
            if ($urandom_range(0, 99) < 8) begin
                pins = MAX_KEYS'($urandom_range(0, 63));
            end else begin
                for (int k = 0; k < MAX_KEYS; k++) begin
                    if (hold_left[k] == 0) begin
                        key_level[k] = ~key_level[k];
                        hold_left[k] = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 2)
                                                                  : $urandom_range(1, span);
                    end
                    hold_left[k]--;
                end
                pins = key_level;
            end
            send_scan(pins);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready drops for a drawn stall before each beat, with
    // stretches of no stalls at all.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int beats;
        i_ready  = 1'b0;
        rx_burst = 1'b0;
        beats    = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (beats % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
            beats++;
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    initial begin
        int idle;
        idle = 0;
        wait (i_rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] settle;
        logic [15:0] long_t;
        logic [15:0] step_word;
        logic [15:0] mask_word;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_pin_levels = '0;
        tx_burst     = 1'b0;
        key_level    = '0;
        cur_settle   = RST_DEBOUNCE_TIME;
        cur_long     = RST_LONG_TIME;
        cur_step     = RST_TICK_STEP;
        for (int k = 0; k < MAX_KEYS; k++)
            hold_left[k] = 0;

        // Directed ticks with debounce 20, long 60, step 10 and mask 6'h2A, so
        // 6'h2A is all keys pressed and 6'h15 all released. Two ticks after a
        // level change it debounces.
        directed_pins = '{
            6'h15, 6'h15, 6'h15,                      // settle released
            6'h2A, 6'h2A, 6'h2A,                      // down on third tick
            6'h2A, 6'h2A, 6'h2A, 6'h2A, 6'h2A, 6'h2A, // press reaches 60: long
            6'h15, 6'h15, 6'h15,                      // release past long: up
            6'h2A, 6'h2A, 6'h2A, 6'h2A,               // down again, brief hold
            6'h15, 6'h15, 6'h15,                      // release inside window: short
            6'h2A, 6'h15,                             // bounce, filtered
            6'h3F, 6'h00                              // mixed polarity extremes
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        configure(16'd20, 16'd60, 16'h000A, 16'h002A);
        for (int n = 0; n < N_DIRECTED; n++)
            send_scan(directed_pins[n]);

        // reset values, written back explicitly
        configure(16'd20, 16'd1000, 16'h000A, 16'h0000);
        run_random(160);

        // zero step, zero times: accept on the first tick after a change, long every
        // held tick; all keys active high
        configure(16'd0, 16'd0, 16'hFF00, 16'hFFFF);
        run_random(110);

        // top of range: debounce only via timer saturation, long press at the
        // saturated press timer
        configure(16'hFFFF, 16'hFFFF, 16'hAAFF, 16'h5515);
        run_random(300);

        // random mid-range settings; now and then long at or below debounce, so
        // no release can be short
        repeat (3) begin
            settle    = 16'($urandom_range(0, 80));
            step_word = 16'($urandom_range(0, 65535));
            if (step_word[7:0] == 8'd0)
                step_word[7:0] = 8'($urandom_range(1, 40));
            else
                step_word[7:0] = 8'((step_word[7:0] % 40) + 1);
            long_t    = 16'(($urandom_range(0, 3) == 0)
                      ? $urandom_range(0, settle)
                      : settle + step_word[7:0] * $urandom_range(0, 25));
            mask_word = 16'($urandom_range(0, 65535));
            configure(settle, long_t, step_word, mask_word);
            run_random(100);
        end

        // all ticks taken: wait for the last beats, then stay idle
        // to catch anything extra
        drain_reports();
        repeat (6) @(negedge i_clk);

        if (fail_count == 0 && reports_open == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
src/kdpc_pkg.sv
src/kdpc_lane.sv
src/kdpc_merge.sv
src/key_debounce_press_classifier.sv
tb/kdpc_press_checker.sv
tb/tb_key_debounce_press_classifier.sv
